// ===== rtl/core/preemptive_priority_scheduler_defines.svh =====
// Assertion macros shared by the scheduler RTL.
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_DEFINES_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define PPS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scheduler check failed");

// Next-cycle implication, checked outside reset
`define PPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scheduler check failed");

`endif

// ===== rtl/core/pps_pkg.sv =====
// Shared types, constants and command codes of the priority scheduler.
package pps_pkg;

  localparam int HEAP_DEPTH = 64;
  localparam int IDX_W      = $clog2(HEAP_DEPTH);
  localparam int OCC_W      = $clog2(HEAP_DEPTH + 1);
  localparam int CHILD_W    = IDX_W + 2;

  // Heap entry
  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  pri;
    logic [15:0] rem;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Read address select
  localparam logic [2:0] RD_PAR   = 3'd0;
  localparam logic [2:0] RD_ROOT  = 3'd1;
  localparam logic [2:0] RD_LAST  = 3'd2;
  localparam logic [2:0] RD_LEFT  = 3'd3;
  localparam logic [2:0] RD_RIGHT = 3'd4;

  // Write data select
  localparam logic [1:0] WR_CARRY = 2'd0;
  localparam logic [1:0] WR_RD    = 2'd1;
  localparam logic [1:0] WR_DEC   = 2'd2;
  localparam logic [1:0] WR_BEST  = 2'd3;

  // Hole position update
  localparam logic [1:0] POS_HOLD = 2'd0;
  localparam logic [1:0] POS_PAR  = 2'd1;
  localparam logic [1:0] POS_BEST = 2'd2;

  // Result status codes
  localparam logic ST_DONE   = 1'b0;
  localparam logic ST_REJECT = 1'b1;

  // Request kinds
  localparam logic FN_ARRIVE = 1'b0;
  localparam logic FN_TICK   = 1'b1;

  typedef struct packed {
    logic       ld_arr;
    logic       rej;
    logic       tick;
    logic       ld_done;
    logic       emit;
    logic       ld_carry;
    logic       ld_left;
    logic       rd_en;
    logic [2:0] rd_sel;
    logic       wr_en;
    logic [1:0] wr_sel;
    logic [1:0] pos_sel;
  } cmd_t;

  typedef struct packed {
    logic             full;
    logic             occ_zero;
    logic             pos_zero;
    logic             up_swap;
    logic             rem_gt1;
    logic             l_ge_occ;
    logic             r_ge_occ;
    logic             dn_swap;
    logic             out_free;
    logic [OCC_W-1:0] occ;
  } sts_t;

endpackage

// ===== rtl/core/pps_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/pps_dp.sv =====
// Scheduler datapath: heap memory, hole walker, compares, time and result registers.
module pps_dp import pps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [15:0] in_job_id,
  input  logic [7:0]  in_priority_req,
  input  logic [15:0] in_duration,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_status,
  output logic [15:0] out_done_id,
  output logic [31:0] out_finish_time
);

  entry_t             carry_r, carry_nxt;
  entry_t             left_r;
  logic [IDX_W-1:0]   pos_r, pos_nxt;
  logic [OCC_W-1:0]   occ_r, occ_nxt;
  logic [31:0]        time_r;
  logic               res_status_r;
  logic [15:0]        res_id_r;
  logic               out_valid_r;
  logic               out_status_r;
  logic [15:0]        out_id_r;
  logic [31:0]        out_time_r;

  entry_t             rd_data, wr_data, best;
  logic [ENTRY_W-1:0] rd_raw;
  logic [IDX_W-1:0]   rd_addr, wr_addr, par_idx, best_idx;
  logic [CHILD_W-1:0] l_idx, r_idx, occ_ext;
  logic               best_is_r;

  // Child and parent index of the hole
  assign l_idx   = {1'b0, pos_r, 1'b1};
  assign r_idx   = l_idx + CHILD_W'(1);
  assign occ_ext = CHILD_W'(occ_r);
  assign par_idx = IDX_W'((pos_r - IDX_W'(1)) >> 1);

  // Preferred child: higher priority, then less time left, then right
  assign rd_data   = entry_t'(rd_raw);
  assign best_is_r = (r_idx < occ_ext) &&
                     ((rd_data.pri > left_r.pri) ||
                      ((rd_data.pri == left_r.pri) && !(left_r.rem < rd_data.rem)));
  assign best      = best_is_r ? rd_data : left_r;
  assign best_idx  = best_is_r ? r_idx[IDX_W-1:0] : l_idx[IDX_W-1:0];

  // Status back to the controller
  always_comb begin
    sts          = '0;
    sts.full     = (occ_r == OCC_W'(HEAP_DEPTH));
    sts.occ_zero = (occ_r == '0);
    sts.pos_zero = (pos_r == '0);
    sts.up_swap  = (rd_data.pri < carry_r.pri);
    sts.rem_gt1  = (rd_data.rem > 16'd1);
    sts.l_ge_occ = (l_idx >= occ_ext);
    sts.r_ge_occ = (r_idx >= occ_ext);
    sts.dn_swap  = (carry_r.pri <= best.pri);
    sts.out_free = !out_valid_r || out_ready;
    sts.occ      = occ_r;
  end

  // Memory port selects
  always_comb begin
    case (cmd.rd_sel)
      RD_PAR:   rd_addr = par_idx;
      RD_ROOT:  rd_addr = '0;
      RD_LAST:  rd_addr = occ_r[IDX_W-1:0];
      RD_LEFT:  rd_addr = l_idx[IDX_W-1:0];
      RD_RIGHT: rd_addr = r_idx[IDX_W-1:0];
      default:  rd_addr = '0;
    endcase
  end

  always_comb begin
    wr_addr = pos_r;
    case (cmd.wr_sel)
      WR_CARRY: wr_data = carry_r;
      WR_RD:    wr_data = rd_data;
      WR_DEC: begin
        wr_data     = rd_data;
        wr_data.rem = rd_data.rem - 16'd1;
        wr_addr     = '0;
      end
      WR_BEST:  wr_data = best;
      default:  wr_data = carry_r;
    endcase
  end

  pps_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (HEAP_DEPTH)
  ) u_heap (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

  // Carried entry, hole position, occupancy
  always_comb begin
    carry_nxt = carry_r;
    pos_nxt   = pos_r;
    occ_nxt   = occ_r;
    if (cmd.ld_arr) begin
      carry_nxt.id  = in_job_id;
      carry_nxt.pri = in_priority_req;
      carry_nxt.rem = in_duration;
      pos_nxt       = occ_r[IDX_W-1:0];
      occ_nxt       = occ_r + OCC_W'(1);
    end
    if (cmd.ld_done) begin
      occ_nxt = occ_r - OCC_W'(1);
    end
    if (cmd.ld_carry) begin
      carry_nxt = rd_data;
      pos_nxt   = '0;
    end
    case (cmd.pos_sel)
      POS_PAR:  pos_nxt = par_idx;
      POS_BEST: pos_nxt = best_idx;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    carry_r <= carry_nxt;
    pos_r   <= pos_nxt;
    if (cmd.ld_left) begin
      left_r <= rd_data;
    end
    if (cmd.rej) begin
      res_status_r <= ST_REJECT;
      res_id_r     <= in_job_id;
    end else if (cmd.ld_done) begin
      res_status_r <= ST_DONE;
      res_id_r     <= rd_data.id;
    end
    if (cmd.emit) begin
      out_status_r <= res_status_r;
      out_id_r     <= res_id_r;
      out_time_r   <= time_r;
    end
  end

  // Control state: occupancy, time, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      time_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
      if (cmd.tick) begin
        time_r <= time_r + 32'd1;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_done_id     = out_id_r;
  assign out_finish_time = out_time_r;

endmodule

// ===== rtl/core/pps_ctrl.sv =====
// Scheduler controller: sequences arrival sift-up, tick, result and sift-down.
module pps_ctrl import pps_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_func,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_UP_RD   = 4'd1;
  localparam logic [3:0] S_UP_CMP  = 4'd2;
  localparam logic [3:0] S_TK_CMP  = 4'd3;
  localparam logic [3:0] S_EMIT    = 4'd4;
  localparam logic [3:0] S_DN_LAST = 4'd5;
  localparam logic [3:0] S_DN_LOAD = 4'd6;
  localparam logic [3:0] S_DN_L    = 4'd7;
  localparam logic [3:0] S_DN_R    = 4'd8;
  localparam logic [3:0] S_DN_CMP  = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       pop_r, pop_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    pop_nxt   = pop_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_func == FN_ARRIVE) begin
            if (sts.full) begin
              cmd.rej   = 1'b1;
              pop_nxt   = 1'b0;
              state_nxt = S_EMIT;
            end else begin
              cmd.ld_arr = 1'b1;
              state_nxt  = S_UP_RD;
            end
          end else begin
            cmd.tick = 1'b1;
            if (!sts.occ_zero) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_ROOT;
              state_nxt  = S_TK_CMP;
            end
          end
        end
      end
      S_UP_RD: begin
        if (sts.pos_zero) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = WR_CARRY;
          state_nxt  = S_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PAR;
          state_nxt  = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        cmd.wr_en = 1'b1;
        if (sts.up_swap) begin
          cmd.wr_sel  = WR_RD;
          cmd.pos_sel = POS_PAR;
          state_nxt   = S_UP_RD;
        end else begin
          cmd.wr_sel = WR_CARRY;
          state_nxt  = S_IDLE;
        end
      end
      S_TK_CMP: begin
        if (sts.rem_gt1) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = WR_DEC;
          state_nxt  = S_IDLE;
        end else begin
          cmd.ld_done = 1'b1;
          pop_nxt     = 1'b1;
          state_nxt   = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = (pop_r && !sts.occ_zero) ? S_DN_LAST : S_IDLE;
        end
      end
      S_DN_LAST: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_LAST;
        state_nxt  = S_DN_LOAD;
      end
      S_DN_LOAD: begin
        cmd.ld_carry = 1'b1;
        state_nxt    = S_DN_L;
      end
      S_DN_L: begin
        if (sts.l_ge_occ) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = WR_CARRY;
          state_nxt  = S_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_LEFT;
          state_nxt  = S_DN_R;
        end
      end
      S_DN_R: begin
        cmd.ld_left = 1'b1;
        if (!sts.r_ge_occ) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_RIGHT;
        end
        state_nxt = S_DN_CMP;
      end
      S_DN_CMP: begin
        cmd.wr_en = 1'b1;
        if (sts.dn_swap) begin
          cmd.wr_sel  = WR_BEST;
          cmd.pos_sel = POS_BEST;
          state_nxt   = S_DN_L;
        end else begin
          cmd.wr_sel = WR_CARRY;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pop_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pop_r   <= pop_nxt;
    end
  end

endmodule

// ===== rtl/core/preemptive_priority_scheduler.sv =====
// Preemptive priority job scheduler on a binary max-heap held in a 64-entry RAM.
// One request at a time. An arrival is rejected when the heap is full; otherwise
// it enters at the end of the heap and climbs while its parent has a lower
// priority. A tick advances time and, on a non-empty heap, decrements the top
// job's remaining time; a top job with at most one unit left completes instead:
// its result is reported, and the last entry moves to the root and sinks. The
// heap RAM has a single read port, so each sift reads one entry at a time. A
// finished result sits in an output register, so the next request can be taken
// while it waits; only a further result stalls until that one is taken.
module preemptive_priority_scheduler import pps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [15:0] in_job_id,
  input  logic [7:0]  in_priority_req,
  input  logic [15:0] in_duration,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_status,
  output logic [15:0] out_done_id,
  output logic [31:0] out_finish_time
);

`include "preemptive_priority_scheduler_defines.svh"

  cmd_t cmd;
  sts_t sts;

  pps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pps_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_job_id       (in_job_id),
    .in_priority_req (in_priority_req),
    .in_duration     (in_duration),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_done_id     (out_done_id),
    .out_finish_time (out_finish_time)
  );

  // Occupancy never passes the heap size
  `PPS_ASSERT_NOW(a_occ_bound, 1'b1, sts.occ <= OCC_W'(HEAP_DEPTH))
  // A rejected arrival holds off the next request while it reports
  `PPS_ASSERT_NEXT(a_rej_busy, in_valid && in_ready && !in_func && sts.full, !in_ready)
  // A tick on an empty heap finishes at once
  `PPS_ASSERT_NEXT(a_empty_tick, in_valid && in_ready && in_func && sts.occ_zero, in_ready)

endmodule
